FILE: rtl/core/lcg_jump_modular_core_assert.svh
// Assertion macros for the LCG jump-ahead core.
// Included by the top level; expects a clock and an active-low reset.
`ifndef LCG_JUMP_MODULAR_CORE_ASSERT_SVH
`define LCG_JUMP_MODULAR_CORE_ASSERT_SVH

// Same-cycle implication.
`define LCGJ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LCGJ_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lcgj_pkg.sv
// Shared types and constants for the LCG jump-ahead core.
// No dependencies; imported by lcgj_mulmod and lcg_jump_modular_core.
`default_nettype none

package lcgj_pkg;

    localparam int unsigned LCGJ_DATA_W     = 64;
    localparam int unsigned LCGJ_STEP_W     = 32;
    localparam int unsigned LCGJ_CFG_IDX_W  = 2;
    localparam int unsigned LCGJ_COUNT_BITS = 32;

    localparam logic [LCGJ_DATA_W-1:0] LCGJ_MOD_RESET = 64'd2147483647;
    localparam logic [LCGJ_DATA_W-1:0] LCGJ_MUL_RESET = 64'd1103515245;
    localparam logic [LCGJ_DATA_W-1:0] LCGJ_INC_RESET = 64'd12345;

    typedef enum logic [LCGJ_CFG_IDX_W-1:0] {
        CFG_MODULUS    = 2'd0,
        CFG_MULTIPLIER = 2'd1,
        CFG_INCREMENT  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        MM_MUL = 1'b0,
        MM_ADD = 1'b1
    } t_mm_op;

    typedef struct packed {
        logic   valid;
        t_mm_op op;
    } t_mm_req;

endpackage

`default_nettype wire

FILE: rtl/core/lcgj_mulmod.sv
// Bit-serial modular multiply (x*y mod m, y taken a bit at a time: a doubling step
// then a conditional add step per bit) and registered modular add. Depends on lcgj_pkg.
`default_nettype none

module lcgj_mulmod
    import lcgj_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mm_req                i_req,
    input  logic [LCGJ_DATA_W-1:0] i_x,
    input  logic [LCGJ_DATA_W-1:0] i_y,
    input  logic [LCGJ_DATA_W-1:0] i_m,
    output logic                   o_done,
    output logic [LCGJ_DATA_W-1:0] o_result
);

    localparam int unsigned W     = LCGJ_DATA_W;
    localparam int unsigned CNT_W = $clog2(LCGJ_DATA_W);

    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_x;
    logic [W-1:0]     r_y;
    logic [CNT_W-1:0] r_cnt;
    logic             r_phase;
    logic             r_active;
    logic             r_done;

    logic [W-1:0] w_u;
    logic [W-1:0] w_v;
    logic [W:0]   w_sum;
    logic [W:0]   w_diff;
    logic [W-1:0] w_mod;

    // Operand select for the shared add-and-reduce; operands are below m.
    always_comb begin
        priority if (i_req.valid && (i_req.op == MM_ADD)) begin
            w_u = i_x;
            w_v = i_y;
        end else if (!r_phase) begin
            w_u = r_acc;
            w_v = r_acc;
        end else begin
            w_u = r_acc;
            w_v = r_x;
        end
    end

    assign w_sum  = {1'b0, w_u} + {1'b0, w_v};
    assign w_diff = w_sum - {1'b0, i_m};
    assign w_mod  = (w_sum >= {1'b0, i_m}) ? w_diff[W-1:0] : w_sum[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_phase  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.valid) begin
                unique case (i_req.op)
                    MM_MUL: begin
                        r_acc    <= '0;
                        r_x      <= i_x;
                        r_y      <= i_y;
                        r_cnt    <= '0;
                        r_phase  <= 1'b0;
                        r_active <= 1'b1;
                    end
                    MM_ADD: begin
                        r_acc  <= w_mod;
                        r_done <= 1'b1;
                    end
                    default: begin
                        r_active <= 1'b0;
                    end
                endcase
            end else if (r_active) begin
                if (!r_phase) begin
                    // double the accumulator
                    r_acc   <= w_mod;
                    r_phase <= 1'b1;
                end else begin
                    // add x where the current bit of y is set, then shift y
                    if (r_y[W-1]) begin
                        r_acc <= w_mod;
                    end
                    r_y     <= {r_y[W-2:0], 1'b0};
                    r_cnt   <= r_cnt + 1'b1;
                    r_phase <= 1'b0;
                    if (r_cnt == CNT_W'(W - 1)) begin
                        r_active <= 1'b0;
                        r_done   <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

`default_nettype wire

FILE: rtl/core/lcg_jump_modular_core.sv
// LCG jump-ahead core: r = (a*r + b) mod m applied step_count times to seed mod m.
// Command channel: an item transfers at a clock edge where start is high and busy
// is low; i_seed_value and i_step_count are sampled then. busy stays high until
// the result is out. The result appears on o_final_value for one cycle, marked by
// o_valid; the receiver cannot stall, so it must take it in that cycle. busy drops
// on the same edge that raises o_valid, so the next item may start right after.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index at the clock
// edge (0 modulus, 1 multiplier, 2 increment); a zero modulus write is dropped.
// Write only while busy is low.
// Operation: all arithmetic runs through one bit-serial modular multiplier that takes
// its second operand one bit at a time and also does the modular adds. An item first
// reduces seed, a and b mod m, then squares the affine map (a multiply, an add and a
// multiply) for every bit of the count below its top set bit, and applies it (a
// multiply and an add) for each set bit; a zero count gives the reduced seed.
// Reset restores the default registers (m=2147483647, a=1103515245, b=12345) and
// returns the core to idle with no result pending.
`default_nettype none

module lcg_jump_modular_core
    import lcgj_pkg::*;
#(
    parameter int unsigned COUNT_BITS = LCGJ_COUNT_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [LCGJ_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LCGJ_DATA_W-1:0]    i_cfg_wdata,
    input  logic                      start,
    input  logic [LCGJ_DATA_W-1:0]    i_seed_value,
    input  logic [LCGJ_STEP_W-1:0]    i_step_count,
    output logic                      busy,
    output logic                      o_valid,
    output logic [LCGJ_DATA_W-1:0]    o_final_value
);

    localparam int unsigned W   = LCGJ_DATA_W;
    localparam int unsigned N_W = (COUNT_BITS < LCGJ_STEP_W) ? COUNT_BITS : LCGJ_STEP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_SEED,
        S_RED_MUL,
        S_RED_INC,
        S_STEP,
        S_APPLY_MUL,
        S_APPLY_ADD,
        S_CROSS_MUL,
        S_CROSS_ADD,
        S_SQUARE
    } t_state;

    logic [W-1:0] r_modulus;
    logic [W-1:0] r_multiplier;
    logic [W-1:0] r_increment;

    t_state       r_state;
    logic [W-1:0] r_r;
    logic [W-1:0] r_ma;
    logic [W-1:0] r_mb;
    logic [N_W-1:0] r_n;
    t_mm_req      r_req;
    logic [W-1:0] r_op_x;
    logic [W-1:0] r_op_y;

    logic         mm_done;
    logic [W-1:0] mm_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= LCGJ_MOD_RESET;
            r_multiplier <= LCGJ_MUL_RESET;
            r_increment  <= LCGJ_INC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODULUS: begin
                    if (i_cfg_wdata != '0) begin
                        r_modulus <= i_cfg_wdata;
                    end
                end
                CFG_MULTIPLIER: r_multiplier <= i_cfg_wdata;
                CFG_INCREMENT:  r_increment  <= i_cfg_wdata;
                default: begin
                    r_modulus <= r_modulus;
                end
            endcase
        end
    end

    lcgj_mulmod u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_req),
        .i_x      (r_op_x),
        .i_y      (r_op_y),
        .i_m      (r_modulus),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

    // Sequencer: reduce the inputs, then walk the count LSB first, applying the
    // affine map where the bit is set and squaring it for the next position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            busy    <= 1'b0;
            o_valid <= 1'b0;
            r_req   <= '{valid: 1'b0, op: MM_MUL};
        end else begin
            o_valid     <= 1'b0;
            r_req.valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        // seed mod m as 1 * seed mod m
                        r_op_x  <= W'(1);
                        r_op_y  <= i_seed_value;
                        r_req   <= '{valid: 1'b1, op: MM_MUL};
                        r_n     <= i_step_count[N_W-1:0];
                        busy    <= 1'b1;
                        r_state <= S_RED_SEED;
                    end
                end
                S_RED_SEED: begin
                    if (mm_done) begin
                        r_r     <= mm_result;
                        r_op_x  <= W'(1);
                        r_op_y  <= r_multiplier;
                        r_req   <= '{valid: 1'b1, op: MM_MUL};
                        r_state <= S_RED_MUL;
                    end
                end
                S_RED_MUL: begin
                    if (mm_done) begin
                        r_ma    <= mm_result;
                        r_op_x  <= W'(1);
                        r_op_y  <= r_increment;
                        r_req   <= '{valid: 1'b1, op: MM_MUL};
                        r_state <= S_RED_INC;
                    end
                end
                S_RED_INC: begin
                    if (mm_done) begin
                        r_mb    <= mm_result;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_n == '0) begin
                        o_final_value <= r_r;
                        o_valid       <= 1'b1;
                        busy          <= 1'b0;
                        r_state       <= S_IDLE;
                    end else if (r_n[0]) begin
                        r_op_x  <= r_ma;
                        r_op_y  <= r_r;
                        r_req   <= '{valid: 1'b1, op: MM_MUL};
                        r_state <= S_APPLY_MUL;
                    end else begin
                        r_op_x  <= r_ma;
                        r_op_y  <= r_mb;
                        r_req   <= '{valid: 1'b1, op: MM_MUL};
                        r_state <= S_CROSS_MUL;
                    end
                end
                S_APPLY_MUL: begin
                    if (mm_done) begin
                        r_op_x  <= mm_result;
                        r_op_y  <= r_mb;
                        r_req   <= '{valid: 1'b1, op: MM_ADD};
                        r_state <= S_APPLY_ADD;
                    end
                end
                S_APPLY_ADD: begin
                    if (mm_done) begin
                        r_r <= mm_result;
                        if ((r_n >> 1) == '0) begin
                            // no higher bits: skip squaring the map
                            o_final_value <= mm_result;
                            o_valid       <= 1'b1;
                            busy          <= 1'b0;
                            r_state       <= S_IDLE;
                        end else begin
                            r_op_x  <= r_ma;
                            r_op_y  <= r_mb;
                            r_req   <= '{valid: 1'b1, op: MM_MUL};
                            r_state <= S_CROSS_MUL;
                        end
                    end
                end
                S_CROSS_MUL: begin
                    if (mm_done) begin
                        r_op_x  <= mm_result;
                        r_op_y  <= r_mb;
                        r_req   <= '{valid: 1'b1, op: MM_ADD};
                        r_state <= S_CROSS_ADD;
                    end
                end
                S_CROSS_ADD: begin
                    if (mm_done) begin
                        // b' = a*b + b uses the old a; square a afterwards
                        r_mb    <= mm_result;
                        r_op_x  <= r_ma;
                        r_op_y  <= r_ma;
                        r_req   <= '{valid: 1'b1, op: MM_MUL};
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    if (mm_done) begin
                        r_ma    <= mm_result;
                        r_n     <= r_n >> 1;
                        r_state <= S_STEP;
                    end
                end
                default: begin
                    busy    <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "lcg_jump_modular_core_assert.svh"

    `LCGJ_ASSERT_NXT(a_start_sets_busy, i_clk, i_rst_n, start && !busy, busy,
                     "accepted item did not raise busy")
    `LCGJ_ASSERT_IMP(a_valid_when_idle, i_clk, i_rst_n, o_valid,
                     !busy && (r_state == S_IDLE), "result strobe while busy")
    `LCGJ_ASSERT_NXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid,
                     "result strobe longer than one cycle")
    `LCGJ_ASSERT_IMP(a_idle_no_request, i_clk, i_rst_n, r_state == S_IDLE,
                     !r_req.valid || busy == 1'b0, "multiplier request while idle")

endmodule

`default_nettype wire
